### src/aspsrv_pkg.sv
// Shared constants, types and helpers for the address space packet server.
// No dependencies; imported by the region map and by the core.
package aspsrv_pkg;

   localparam int REGIONS      = 4;
   localparam int REGION_DEPTH = 1024;
   localparam int CFG_COUNT    = 4;
   localparam int CFG_IW       = $clog2(CFG_COUNT);
   localparam int CFG_W        = 50;
   localparam int LOOKUP_N     = (REGIONS < CFG_COUNT) ? REGIONS : CFG_COUNT;
   localparam int REGION_IW    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int STORE_DEPTH  = REGIONS * REGION_DEPTH;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int ADDR_W       = 24;
   localparam int CMD_W        = 8;
   localparam int WORD_W       = 32;

   localparam logic [CMD_W-1:0] CMD_WRITE = 8'h00;
   localparam logic [CMD_W-1:0] CMD_READ  = 8'h10;
   localparam logic [CMD_W-1:0] CMD_BURST = 8'h20;

   typedef logic [CFG_W-1:0] region_desc_type;

   typedef enum logic [1:0] {
      WIDTH_BYTE = 2'd0,
      WIDTH_HALF = 2'd1,
      WIDTH_WORD = 2'd2,
      WIDTH_NONE = 2'd3
   } width_code_type;

   typedef struct packed {
      logic                hit;
      logic                usable;   // hit, width legal and offset below REGION_DEPTH
      logic [WORD_W-1:0]   mask;
      logic [STORE_AW-1:0] index;
   } lookup_type;

   function automatic logic [WORD_W-1:0] width_mask(input width_code_type code);
      logic [WORD_W-1:0] m;
      begin
         unique case (code)
            WIDTH_BYTE: m = 32'h0000_00ff;
            WIDTH_HALF: m = 32'h0000_ffff;
            WIDTH_WORD: m = 32'hffff_ffff;
            default:    m = 32'h0000_0000;
         endcase
         return m;
      end
   endfunction

endpackage

### src/address_space_packet_server_core.sv
// Top level of the address space packet server: request parser, element
// store, reply buffer. Depends on aspsrv_pkg and aspsrv_region_map.
//
// Usage:
//   Request words enter on req_* (valid/stall); a beat is taken at a rising
//   edge with req_valid high and req_stall low. Reply words leave on rsp_*
//   under the same rule, with rsp_stall driven by the receiver.
//   Region descriptors are written through csr_write/csr_index/csr_data,
//   only while no packet is in progress.
// Flow: reply words of a request beat pass through the reply buffer, then
//   the output register, to rsp_*. A request word gives zero, one or two
//   reply words; one reply word leaves per cycle while rsp_stall is low, and
//   a word yielding two replies holds off the next request word until its
//   first reply has left. The single reply buffer stage and the
//   one-word-per-cycle output register set this rate. Reads hit the element
//   store at acceptance; the read data is held until its reply word is sent.
// Reset: synchronous, active high. Afterwards the element store is cleared
//   one entry per cycle (STORE_DEPTH entries, 4096 at the default sizes);
//   req_stall stays high during that sweep. CSR writes are taken throughout.
// Stall: with rsp_stall high the output register holds its beat; the reply
//   buffer fills and req_stall rises until the buffer can drain.
module address_space_packet_server_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [aspsrv_pkg::CFG_IW-1:0]    csr_index,
   input  logic [aspsrv_pkg::CFG_W-1:0]     csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [aspsrv_pkg::WORD_W-1:0]    req_packet_word,
   input  logic                             req_last_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [aspsrv_pkg::WORD_W-1:0]    rsp_reply_word,
   output logic                             rsp_reply_end,
   output logic                             rsp_truncated
);
   import aspsrv_pkg::*;

   typedef enum logic [5:0] {
      PH_ID0   = 6'b000001,
      PH_ID1   = 6'b000010,
      PH_CMD   = 6'b000100,
      PH_DATA  = 6'b001000,
      PH_INNER = 6'b010000,
      PH_BURST = 6'b100000
   } phase_type;

   // configuration
   region_desc_type [CFG_COUNT-1:0] region_ff;

   // parser state
   phase_type         phase_ff, phase_in;
   logic [CMD_W-1:0]  held_cmd_ff, held_cmd_in;
   logic [ADDR_W-1:0] held_addr_ff, held_addr_in;
   logic [ADDR_W-1:0] repeats_ff, repeats_in;

   // element store and clearing sweep
   logic [WORD_W-1:0]   store_mem [STORE_DEPTH];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                clearing_ff;
   logic [STORE_AW-1:0] clr_addr_ff;

   // reply buffer: up to two words; cnt 2 -> word0 next, cnt 1 -> word1 next
   logic [1:0]        p1_cnt_ff, p1_cnt_in;
   logic [WORD_W-1:0] p1_w0_ff, p1_w1_ff;
   logic              p1_e1_ff, p1_t1_ff, p1_mem_ff;
   logic [WORD_W-1:0] p1_mask_ff;

   // output register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_end_ff, rsp_trunc_ff;

   // parse results
   logic [1:0]        n_res;
   logic [WORD_W-1:0] w0_in, w1_in, mask_in;
   logic              e1_in, t1_in, mem_in;
   logic              beat;
   logic [CMD_W-1:0]  cmd;

   lookup_type        lk;
   logic              accept, out_ready, out_move, p1_free;
   logic              do_write, do_read;
   logic [WORD_W-1:0] head_word;
   logic              head_end, head_trunc;

   aspsrv_region_map u_map (
      .regions (region_ff),
      .addr    (held_addr_ff),
      .result  (lk)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign out_move  = (p1_cnt_ff != 2'd0) && out_ready;
   assign p1_free   = (p1_cnt_ff == 2'd0) || ((p1_cnt_ff == 2'd1) && out_ready);
   assign req_stall = clearing_ff || !p1_free;
   assign accept    = req_valid && !req_stall;

   assign cmd  = req_packet_word[WORD_W-1:WORD_W-CMD_W];
   assign beat = (phase_ff == PH_DATA) || (phase_ff == PH_BURST);

   always_comb begin
      phase_in     = phase_ff;
      held_cmd_in  = held_cmd_ff;
      held_addr_in = held_addr_ff;
      repeats_in   = repeats_ff;
      n_res        = 2'd0;
      w0_in        = '0;
      w1_in        = '0;
      e1_in        = req_last_word;
      t1_in        = 1'b0;
      mem_in       = 1'b0;
      mask_in      = '0;
      unique case (phase_ff)
         PH_ID0: begin
            if (req_last_word) begin
               n_res    = 2'd2;
               w0_in    = req_packet_word;
               t1_in    = 1'b1;
               phase_in = PH_ID0;
            end else begin
               n_res    = 2'd1;
               w1_in    = req_packet_word;
               phase_in = PH_ID1;
            end
         end
         PH_ID1: begin
            n_res    = 2'd1;
            w1_in    = req_packet_word;
            phase_in = req_last_word ? PH_ID0 : PH_CMD;
         end
         PH_CMD: begin
            if (cmd == CMD_BURST) begin
               repeats_in = req_packet_word[ADDR_W-1:0];
               if (req_last_word) begin
                  n_res    = 2'd2;
                  w0_in    = {CMD_BURST, req_packet_word[ADDR_W-1:0]};
                  t1_in    = 1'b1;
                  phase_in = PH_ID0;
               end else begin
                  phase_in = PH_INNER;
               end
            end else begin
               held_cmd_in  = cmd;
               held_addr_in = req_packet_word[ADDR_W-1:0];
               if (req_last_word) begin
                  n_res    = 2'd1;
                  t1_in    = 1'b1;
                  phase_in = PH_ID0;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            n_res    = 2'd2;
            w0_in    = {held_cmd_ff, held_addr_ff};
            phase_in = req_last_word ? PH_ID0 : PH_CMD;
         end
         PH_INNER: begin
            held_cmd_in  = cmd;
            held_addr_in = req_packet_word[ADDR_W-1:0];
            n_res        = 2'd1;
            w1_in        = {CMD_BURST, repeats_ff};
            if (req_last_word)
               phase_in = PH_ID0;
            else
               phase_in = (repeats_ff != '0) ? PH_BURST : PH_CMD;
         end
         PH_BURST: begin
            n_res      = 2'd2;
            w0_in      = {held_cmd_ff, held_addr_ff};
            repeats_in = repeats_ff - 1'b1;
            if (req_last_word)
               phase_in = PH_ID0;
            else
               phase_in = (repeats_in != '0) ? PH_BURST : PH_CMD;
         end
         default: begin
            phase_in = PH_ID0;
         end
      endcase

      // data word of a beat: reads come from the store, masked (0 if unmapped)
      if (beat) begin
         if (held_cmd_ff == CMD_READ) begin
            mem_in  = 1'b1;
            mask_in = lk.usable ? lk.mask : '0;
         end else begin
            w1_in = req_packet_word;
         end
      end
   end

   assign do_write = accept && beat && (held_cmd_ff == CMD_WRITE) && lk.usable;
   assign do_read  = accept && beat && (held_cmd_ff == CMD_READ) && lk.usable;

   // element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clearing_ff)
         store_mem[clr_addr_ff] <= '0;
      else if (do_write)
         store_mem[lk.index] <= req_packet_word & lk.mask;
      if (do_read)
         rd_data_ff <= store_mem[lk.index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == STORE_AW'(STORE_DEPTH - 1))
            clearing_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= '0;
      end else if (csr_write) begin
         region_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ID0;
         held_cmd_ff  <= '0;
         held_addr_ff <= '0;
         repeats_ff   <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         held_cmd_ff  <= held_cmd_in;
         held_addr_ff <= held_addr_in;
         repeats_ff   <= repeats_in;
      end
   end

   // reply buffer
   always_comb begin
      p1_cnt_in = p1_cnt_ff;
      if (accept)
         p1_cnt_in = n_res;
      else if (out_move)
         p1_cnt_in = p1_cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         p1_cnt_ff <= '0;
      else
         p1_cnt_ff <= p1_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_w0_ff   <= w0_in;
         p1_w1_ff   <= w1_in;
         p1_e1_ff   <= e1_in;
         p1_t1_ff   <= t1_in;
         p1_mem_ff  <= mem_in;
         p1_mask_ff <= mask_in;
      end
   end

   always_comb begin
      if (p1_cnt_ff == 2'd2) begin
         head_word  = p1_w0_ff;
         head_end   = 1'b0;
         head_trunc = 1'b0;
      end else begin
         head_word  = p1_mem_ff ? (rd_data_ff & p1_mask_ff) : p1_w1_ff;
         head_end   = p1_e1_ff;
         head_trunc = p1_t1_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_ready)
         rsp_valid_ff <= out_move;
   end

   always_ff @(posedge clock) begin
      if (out_move) begin
         rsp_word_ff  <= head_word;
         rsp_end_ff   <= head_end;
         rsp_trunc_ff <= head_trunc;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_word = rsp_word_ff;
   assign rsp_reply_end  = rsp_end_ff;
   assign rsp_truncated  = rsp_trunc_ff;

endmodule

### src/aspsrv_region_map.sv
// Address decoder: finds the lowest numbered region holding an address and
// forms the element store index and width mask. Depends on aspsrv_pkg.
module aspsrv_region_map (
   input  aspsrv_pkg::region_desc_type [aspsrv_pkg::CFG_COUNT-1:0] regions,
   input  logic [aspsrv_pkg::ADDR_W-1:0]                           addr,
   output aspsrv_pkg::lookup_type                                  result
);
   import aspsrv_pkg::*;

   logic                 found;
   logic [REGION_IW-1:0] sel;
   logic [ADDR_W-1:0]    offset;
   width_code_type       code;
   logic [ADDR_W-1:0]    base;
   logic [ADDR_W-1:0]    size;
   logic [WORD_W-1:0]    mask;

   always_comb begin
      found  = 1'b0;
      sel    = '0;
      offset = '0;
      code   = WIDTH_NONE;
      base   = '0;
      size   = '0;
      for (int r = 0; r < LOOKUP_N; r++) begin
         base = regions[r][ADDR_W-1:0];
         size = regions[r][2*ADDR_W-1:ADDR_W];
         if (!found && size != '0 && addr >= base && (addr - base) < size) begin
            found  = 1'b1;
            sel    = REGION_IW'(r);
            offset = addr - base;
            code   = width_code_type'(regions[r][CFG_W-1:2*ADDR_W]);
         end
      end
      mask = width_mask(code);
   end

   assign result.hit    = found;
   assign result.usable = found && (mask != '0) && (offset < ADDR_W'(REGION_DEPTH));
   assign result.mask   = mask;
   assign result.index  = STORE_AW'(STORE_AW'(sel) * STORE_AW'(REGION_DEPTH))
                        + STORE_AW'(offset);

endmodule

### sim/address_space_packet_server_core_tb.sv
// Self-checking bench for address_space_packet_server_core: a beat-level predictor,
// random request packets, random request gaps and reply stalls. Needs aspsrv_pkg and the RTL.
module address_space_packet_server_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aspsrv_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int HOT_N        = 8;
   localparam int CSR_SETTLE   = 8;
   localparam int END_SETTLE   = 20;
   localparam int REPORT_CAP   = 40;

   localparam int REG_REGION0 = 0;
   localparam int REG_REGION1 = 1;
   localparam int REG_REGION2 = 2;
   localparam int REG_REGION3 = 3;

   localparam logic [CMD_W-1:0] CMD_ALL_ONES = 8'hff;

   typedef enum logic [5:0] {
      AT_ID_FIRST  = 6'b000001,
      AT_ID_SECOND = 6'b000010,
      AT_OPCODE    = 6'b000100,
      AT_DATA      = 6'b001000,
      AT_INNER     = 6'b010000,
      AT_REPEAT    = 6'b100000
   } parse_state_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              ends;
      logic              cut;
   } reply_beat_type;

   logic                clock;
   logic                reset           = 1'b1;
   logic                csr_write       = 1'b0;
   logic [CFG_IW-1:0]   csr_index       = '0;
   logic [CFG_W-1:0]    csr_data        = '0;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [WORD_W-1:0]   req_packet_word = '0;
   logic                req_last_word   = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [WORD_W-1:0]   rsp_reply_word;
   logic                rsp_reply_end;
   logic                rsp_truncated;

   // stimulus and scoreboard state
   req_item_type        request_words[$];
   reply_beat_type      pending_replies[$];
   req_item_type        next_item;
   reply_beat_type      exp_beat;
   int                  words_outstanding = 0;
   int                  items_sent        = 0;
   int                  mismatch_count    = 0;
   int                  send_idle_pct     = 24;
   int                  recv_idle_pct     = 75;
   bit                  req_beat_taken    = 1'b0;
   logic [ADDR_W-1:0]   hot_addr[HOT_N];

   // predictor state
   region_desc_type     region_desc[CFG_COUNT];
   parse_state_type     parse_state;
   logic [CMD_W-1:0]    held_op;
   logic [ADDR_W-1:0]   held_addr;
   logic [ADDR_W-1:0]   repeats_left;
   logic [WORD_W-1:0]   element_mirror[STORE_DEPTH];

   address_space_packet_server_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_packet_word (req_packet_word),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reply_word  (rsp_reply_word),
      .rsp_reply_end   (rsp_reply_end),
      .rsp_truncated   (rsp_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** address_space_packet_server_core: FAILED **");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < REPORT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic expect_reply(input logic [WORD_W-1:0] w, input logic ends, input logic cut);
      pending_replies.push_back('{word: w, ends: ends, cut: cut});
   endtask

   // Applies one command at one address; returns the data word of the reply.
   function automatic logic [WORD_W-1:0] apply_beat(input logic [CMD_W-1:0] op,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [WORD_W-1:0] data);
      logic [WORD_W-1:0] keep;
      logic [ADDR_W-1:0] base, size, off;
      logic [WORD_W-1:0] reply;
      width_code_type    code;
      bit                hit;
      int                slot, r, idx;
      reply = data;
      hit   = 1'b0;
      slot  = 0;
      off   = '0;
      if (op == CMD_WRITE || op == CMD_READ) begin
         for (r = 0; r < LOOKUP_N; r++) begin
            base = region_desc[r][ADDR_W-1:0];
            size = region_desc[r][2*ADDR_W-1:ADDR_W];
            if (!hit && size != '0 && addr >= base && (addr - base) < size) begin
               hit  = 1'b1;
               slot = r;
               off  = addr - base;
            end
         end
         if (op == CMD_READ) reply = '0;
         if (hit) begin
            code = width_code_type'(region_desc[slot][2*ADDR_W+1:2*ADDR_W]);
            case (code)
               WIDTH_BYTE: keep = 32'h0000_00ff;
               WIDTH_HALF: keep = 32'h0000_ffff;
               WIDTH_WORD: keep = 32'hffff_ffff;
               default:    keep = 32'h0000_0000;
            endcase
            // elements past the region's depth and width-less regions are inert
            if (int'(off) < REGION_DEPTH && keep != '0) begin
               idx = slot * REGION_DEPTH + int'(off);
               if (op == CMD_WRITE) element_mirror[idx] = data & keep;
               else reply = element_mirror[idx] & keep;
            end
         end
      end
      return reply;
   endfunction

   task automatic decode_request_word(input logic [WORD_W-1:0] w, input logic last);
      logic [CMD_W-1:0] op;
      op = w[31:24];
      case (parse_state)
         AT_ID_FIRST: begin
            expect_reply(w, 1'b0, 1'b0);
            if (last) expect_reply('0, 1'b1, 1'b1);
            else parse_state = AT_ID_SECOND;
         end
         AT_ID_SECOND: begin
            expect_reply(w, last, 1'b0);
            parse_state = last ? AT_ID_FIRST : AT_OPCODE;
         end
         AT_OPCODE: begin
            if (op == CMD_BURST) begin
               repeats_left = w[ADDR_W-1:0];
               if (last) begin
                  expect_reply({CMD_BURST, repeats_left}, 1'b0, 1'b0);
                  expect_reply('0, 1'b1, 1'b1);
                  parse_state = AT_ID_FIRST;
               end else begin
                  parse_state = AT_INNER;
               end
            end else begin
               held_op   = op;
               held_addr = w[ADDR_W-1:0];
               if (last) begin
                  expect_reply('0, 1'b1, 1'b1);
                  parse_state = AT_ID_FIRST;
               end else begin
                  parse_state = AT_DATA;
               end
            end
         end
         AT_DATA: begin
            expect_reply({held_op, held_addr}, 1'b0, 1'b0);
            expect_reply(apply_beat(held_op, held_addr, w), last, 1'b0);
            parse_state = last ? AT_ID_FIRST : AT_OPCODE;
         end
         AT_INNER: begin
            held_op   = op;
            held_addr = w[ADDR_W-1:0];
            expect_reply({CMD_BURST, repeats_left}, last, 1'b0);
            if (last) parse_state = AT_ID_FIRST;
            else parse_state = (repeats_left != '0) ? AT_REPEAT : AT_OPCODE;
         end
         AT_REPEAT: begin
            expect_reply({held_op, held_addr}, 1'b0, 1'b0);
            expect_reply(apply_beat(held_op, held_addr, w), last, 1'b0);
            repeats_left = repeats_left - 24'd1;
            if (last) parse_state = AT_ID_FIRST;
            else parse_state = (repeats_left != '0) ? AT_REPEAT : AT_OPCODE;
         end
         default: parse_state = AT_ID_FIRST;
      endcase
   endtask

   // Request driver: new beat only when the line is free or the last beat was taken.
   always @(negedge clock) begin
      if (!req_valid || req_beat_taken) begin
         if (!reset && request_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_item = request_words.pop_front();
            req_valid       <= 1'b1;
            req_packet_word <= next_item.word;
            req_last_word   <= next_item.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_beat_taken = 1'b0;
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Monitor: predicts on each accepted request beat, checks each reply beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_request_word(req_packet_word, req_last_word);
            words_outstanding--;
            req_beat_taken = 1'b1;
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               flag_mismatch($sformatf("reply beat %h with nothing expected", rsp_reply_word));
            end else begin
               exp_beat = pending_replies.pop_front();
               if (rsp_reply_word !== exp_beat.word)
                  flag_mismatch($sformatf("reply_word %h, expected %h",
                                          rsp_reply_word, exp_beat.word));
               if (rsp_reply_end !== exp_beat.ends)
                  flag_mismatch($sformatf("reply_end %b, expected %b on word %h",
                                          rsp_reply_end, exp_beat.ends, exp_beat.word));
               if (rsp_truncated !== exp_beat.cut)
                  flag_mismatch($sformatf("truncated %b, expected %b on word %h",
                                          rsp_truncated, exp_beat.cut, exp_beat.word));
            end
         end
      end
   end

   task automatic queue_word(input logic [WORD_W-1:0] w, input logic last);
      request_words.push_back('{word: w, last: last});
      words_outstanding++;
      items_sent++;
   endtask

   // Waits until every queued word is taken and every reply has come, then idles a bit.
   task automatic settle(input int extra);
      while (words_outstanding != 0 || pending_replies.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   function automatic region_desc_type make_desc(input width_code_type code,
                                                 input logic [ADDR_W-1:0] size,
                                                 input logic [ADDR_W-1:0] base);
      return {code, size, base};
   endfunction

   task automatic write_region(input int idx, input region_desc_type d);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CFG_IW'(idx);
      csr_data  <= d;
      region_desc[idx] = d;
   endtask

   task automatic program_regions(input region_desc_type d0, input region_desc_type d1,
                                  input region_desc_type d2, input region_desc_type d3);
      write_region(REG_REGION0, d0);
      write_region(REG_REGION1, d1);
      write_region(REG_REGION2, d2);
      write_region(REG_REGION3, d3);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Command/address word: mostly reads and writes, often near configured regions;
   // many addresses revisit recently written ones.
   function automatic logic [WORD_W-1:0] pick_cmd_addr();
      logic [CMD_W-1:0]  op;
      logic [ADDR_W-1:0] addr, base, size;
      int                roll, r, lim;
      roll = $urandom_range(0, 99);
      if (roll < 40) op = CMD_WRITE;
      else if (roll < 80) op = CMD_READ;
      else if (roll < 88) op = CMD_ALL_ONES;
      else begin
         op = CMD_W'($urandom);
         if (op == CMD_WRITE || op == CMD_READ || op == CMD_BURST) op = CMD_ALL_ONES;
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         addr = hot_addr[$urandom_range(0, HOT_N - 1)];
      end else if (roll < 55) begin
         addr = ADDR_W'($urandom);
      end else begin
         r    = $urandom_range(0, CFG_COUNT - 1);
         base = region_desc[r][ADDR_W-1:0];
         size = region_desc[r][2*ADDR_W-1:ADDR_W];
         lim  = (int'(size) > REGION_DEPTH) ? REGION_DEPTH + 4 : int'(size) + 1;
         addr = base + ADDR_W'($urandom_range(0, lim));
      end
      if (op == CMD_WRITE) hot_addr[$urandom_range(0, HOT_N - 1)] = addr;
      return {op, addr};
   endfunction

   // One request packet; most are well formed, some end early inside a beat or burst.
   task automatic queue_packet(input bit pause_midway);
      req_item_type      pkt[$];
      logic [ADDR_W-1:0] count;
      int                shape, beats, b, k, n, i;
      shape = $urandom_range(0, 99);
      pkt.push_back('{word: $urandom, last: 1'b0});
      if (shape >= 4) begin
         pkt.push_back('{word: $urandom, last: 1'b0});
         beats = $urandom_range(0, 5);
         for (b = 0; b < beats; b++) begin
            if ($urandom_range(0, 99) < 20) begin
               count = ADDR_W'($urandom_range(0, 4));
               pkt.push_back('{word: {CMD_BURST, count}, last: 1'b0});
               pkt.push_back('{word: pick_cmd_addr(), last: 1'b0});
               for (k = 0; k < int'(count); k++) pkt.push_back('{word: $urandom, last: 1'b0});
            end else begin
               pkt.push_back('{word: pick_cmd_addr(), last: 1'b0});
               pkt.push_back('{word: $urandom, last: 1'b0});
            end
         end
         if (shape < 18) begin
            count = ADDR_W'($urandom);
            case ($urandom_range(0, 3))
               0: pkt.push_back('{word: pick_cmd_addr(), last: 1'b0});
               1: pkt.push_back('{word: {CMD_BURST, count}, last: 1'b0});
               2: begin
                  pkt.push_back('{word: {CMD_BURST, count}, last: 1'b0});
                  pkt.push_back('{word: pick_cmd_addr(), last: 1'b0});
               end
               default: begin
                  // burst cut short before its count runs out
                  n = $urandom_range(1, 3);
                  if (int'(count) <= n) count = ADDR_W'(n + 1);
                  pkt.push_back('{word: {CMD_BURST, count}, last: 1'b0});
                  pkt.push_back('{word: pick_cmd_addr(), last: 1'b0});
                  for (k = 0; k < n; k++) pkt.push_back('{word: $urandom, last: 1'b0});
               end
            endcase
         end
      end
      pkt[pkt.size() - 1].last = 1'b1;
      for (i = 0; i < pkt.size(); i++) begin
         if (pause_midway && i == pkt.size() / 2) settle(0);
         queue_word(pkt[i].word, pkt[i].last);
      end
   endtask

   initial begin
      int ph, start, r;
      bit paused;
      parse_state  = AT_ID_FIRST;
      held_op      = '0;
      held_addr    = '0;
      repeats_left = '0;
      for (r = 0; r < CFG_COUNT; r++) region_desc[r] = '0;
      for (r = 0; r < STORE_DEPTH; r++) element_mirror[r] = '0;
      for (r = 0; r < HOT_N; r++) hot_addr[r] = '0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // byte region overlapped by a width-less one, halfword region deeper than
      // REGION_DEPTH, word region running past the top of the address space
      program_regions(make_desc(WIDTH_BYTE, 24'h000040, 24'h000100),
                      make_desc(WIDTH_HALF, 24'h000800, 24'h001000),
                      make_desc(WIDTH_WORD, 24'hffffff, 24'hffff00),
                      make_desc(WIDTH_NONE, 24'h000100, 24'h000120));

      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'hffff_ffff, 1'b0);
      queue_word({CMD_WRITE, 24'h000100}, 1'b0);
      queue_word(32'hffff_ffff, 1'b0);
      queue_word({CMD_READ, 24'h000100}, 1'b0);
      queue_word(32'h0000_0000, 1'b0);
      queue_word({CMD_ALL_ONES, 24'hffffff}, 1'b0);
      queue_word(32'hdead_beef, 1'b1);
      // packet ending on its first id word
      queue_word(32'h1234_5678, 1'b1);
      // ending on a command word, then on a burst word
      queue_word(32'h5a5a_5a5a, 1'b0);
      queue_word(32'ha5a5_a5a5, 1'b0);
      queue_word({CMD_READ, 24'h000130}, 1'b1);
      queue_word(32'h0f0f_0f0f, 1'b0);
      queue_word(32'hf0f0_f0f0, 1'b0);
      queue_word({CMD_BURST, 24'hffffff}, 1'b1);
      // full burst of two halfword writes, then a read back
      queue_word(32'h0000_0001, 1'b0);
      queue_word(32'h0000_0002, 1'b0);
      queue_word({CMD_BURST, 24'd2}, 1'b0);
      queue_word({CMD_WRITE, 24'h001004}, 1'b0);
      queue_word(32'hcafe_f00d, 1'b0);
      queue_word(32'h8001_7ffe, 1'b0);
      queue_word({CMD_READ, 24'h001004}, 1'b0);
      queue_word(32'h0000_0000, 1'b1);
      // zero-count burst, then a short burst reading a width-less region
      queue_word(32'h0000_0003, 1'b0);
      queue_word(32'h0000_0004, 1'b0);
      queue_word({CMD_BURST, 24'd0}, 1'b0);
      queue_word({CMD_READ, 24'h001500}, 1'b0);
      queue_word({CMD_BURST, 24'd5}, 1'b0);
      queue_word({CMD_READ, 24'h000140}, 1'b0);
      queue_word(32'h5555_aaaa, 1'b1);

      for (ph = 0; ph < 3; ph++) begin
         settle(CSR_SETTLE);
         case (ph)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 75;
               program_regions(make_desc(WIDTH_WORD, 24'd1024, 24'h000000),
                               make_desc(WIDTH_BYTE, 24'h000010, 24'hfffff0),
                               make_desc(WIDTH_HALF, 24'hffffff, 24'h000000),
                               '1);
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 24;
               program_regions('0,
                               make_desc(WIDTH_HALF, 24'h000400, 24'h400000),
                               make_desc(WIDTH_BYTE, 24'h000800, 24'h400200),
                               make_desc(WIDTH_WORD, 24'h000001, 24'h000000));
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               program_regions(
                  make_desc(width_code_type'($urandom_range(0, 3)),
                            ADDR_W'($urandom_range(1, 1100)), ADDR_W'($urandom)),
                  make_desc(width_code_type'($urandom_range(0, 3)),
                            ADDR_W'($urandom_range(1, 1100)), ADDR_W'($urandom)),
                  make_desc(width_code_type'($urandom_range(0, 3)),
                            ADDR_W'($urandom_range(1, 1100)), ADDR_W'($urandom)),
                  make_desc(width_code_type'($urandom_range(0, 3)),
                            ADDR_W'($urandom_range(1, 1100)), ADDR_W'($urandom)));
            end
         endcase
         start  = items_sent;
         paused = 1'b0;
         while (items_sent - start < RANDOM_ITEMS / 3) begin
            if (!paused && items_sent - start >= RANDOM_ITEMS / 6) begin
               queue_packet(1'b1);
               paused = 1'b1;
            end else begin
               queue_packet(1'b0);
            end
         end
      end

      settle(END_SETTLE);
      if (mismatch_count == 0) begin
         $display("** address_space_packet_server_core: PASSED **");
      end else begin
         $display("** address_space_packet_server_core: FAILED **");
      end
      $finish;
   end

endmodule
